[rtl/assert_macros.svh]
// Assertion macros shared by the radix digit emitter RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/rde_pkg.sv]
// Shared types and constants for the radix digit emitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package rde_pkg;

  localparam int DEF_VALUE_BITS  = 32;
  localparam int DEF_MAX_SYMBOLS = 16;

  localparam int IN_VALUE_W  = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_W     = 5;
  localparam int CHAR_W      = 8;
  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  // quotient bits resolved per divider cycle
  localparam int STEP_BITS   = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHABET_HIGH = 2'd2;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    ST_DIGIT = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef logic [NUM_SLOTS-1:0][CHAR_W-1:0] alpha_t;

  typedef struct packed {
    logic [COUNT_W-1:0] base;
    alpha_t             alpha;
  } alpha_cfg_t;

  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    store;
    logic    rd;
    logic    special;
    logic    last;
    status_t spec_status;
  } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/rde_cfg.sv]
// Configuration registers and alphabet validity check.
// Depends on rde_pkg.
`default_nettype none

module rde_cfg #(
  parameter int MAX_SYMBOLS = rde_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rde_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rde_pkg::CFG_DATA_W-1:0]      cfg_data,
  output rde_pkg::alpha_cfg_t                 cfg_o,
  output logic                                alpha_bad
);
  import rde_pkg::*;

  logic [COUNT_W-1:0]    count_r;
  logic [CFG_DATA_W-1:0] alpha_lo_r;
  logic [CFG_DATA_W-1:0] alpha_hi_r;
  logic                  bad_r;
  logic                  bad_nxt;
  alpha_t                alpha;

  // hold writes off while an item is pending or running
  assign cfg_ready = !busy && !start;
  assign alpha     = {alpha_hi_r, alpha_lo_r};

  // count range check, reserved-character check and pairwise symbol compare; only slots below the count take part
  always_comb begin
    bad_nxt = (count_r < COUNT_W'(2)) || (count_r > COUNT_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (COUNT_W'(i) < count_r) begin
        if (alpha[i] == CH_MINUS || alpha[i] == CH_PLUS || alpha[i] == CH_DOT) begin
          bad_nxt = 1'b1;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (COUNT_W'(j) < count_r && alpha[j] == alpha[i]) begin
            bad_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      alpha_lo_r <= '0;
      alpha_hi_r <= '0;
      bad_r      <= 1'b1;
    end else begin
      bad_r <= bad_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SYMBOL_COUNT:  count_r    <= cfg_data[COUNT_W-1:0];
          REG_ALPHABET_LOW:  alpha_lo_r <= cfg_data;
          REG_ALPHABET_HIGH: alpha_hi_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign cfg_o.base  = count_r;
  assign cfg_o.alpha = alpha;
  assign alpha_bad   = bad_r;

endmodule

`default_nettype wire

[rtl/rde_ctrl.sv]
// Sequencer: status beat, or divide one chunk a cycle, store digits, read them back.
// Depends on rde_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rde_ctrl #(
  parameter int VALUE_BITS = rde_pkg::DEF_VALUE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          in_suppress_zero,
  output logic                          busy,
  input  logic                          q_zero,
  input  logic                          alpha_bad,
  output rde_pkg::dp_cmd_t              cmd,
  output logic [$clog2(VALUE_BITS)-1:0] idx
);
  import rde_pkg::*;

  localparam int NCH  = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int IW   = $clog2(VALUE_BITS);
  localparam logic [CNTW-1:0] LAST_CHUNK = CNTW'(NCH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_STORE,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic            sup_r, sup_nxt;
  logic [CNTW-1:0] chunk_r, chunk_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    sup_nxt   = sup_r;
    chunk_nxt = chunk_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          sup_nxt   = in_suppress_zero;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        chunk_nxt = '0;
        idx_nxt   = '0;
        if (q_zero && sup_r) begin
          cmd.special     = 1'b1;
          cmd.last        = 1'b1;
          cmd.spec_status = ST_EMPTY;
          state_nxt       = S_IDLE;
        end else if (alpha_bad) begin
          cmd.special     = 1'b1;
          cmd.last        = 1'b1;
          cmd.spec_status = ST_BAD;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        chunk_nxt    = chunk_r + 1'b1;
        if (chunk_r == LAST_CHUNK) begin
          chunk_nxt = '0;
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        // zero quotient: this digit is the most significant, read back from here
        if (q_zero) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_EMIT: begin
        cmd.rd   = 1'b1;
        cmd.last = (idx_r == '0);
        idx_nxt  = idx_r - 1'b1;
        if (idx_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sup_r   <= sup_nxt;
    chunk_r <= chunk_nxt;
    idx_r   <= idx_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign idx  = idx_r;

  `ASSERT_SYNC(a_one_cmd, $onehot0({cmd.load, cmd.div_step, cmd.store, cmd.rd, cmd.special}), "more than one datapath command")
  `ASSERT_SYNC(a_store_after_div, (state_r == S_STORE) |-> ($past(state_r) == S_DIV), "digit stored without a division pass")
  `ASSERT_SYNC(a_idle_after_last, (state_r == S_IDLE && $past(state_r) != S_IDLE) |-> $past(cmd.special || (cmd.rd && cmd.last)), "item ended without a last beat")

endmodule

`default_nettype wire

[rtl/rde_dpath.sv]
// Datapath: chunked restoring divider, digit store and output registers.
// Depends on rde_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rde_dpath #(
  parameter int VALUE_BITS = rde_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rde_pkg::dp_cmd_t                  cmd,
  input  logic [$clog2(VALUE_BITS)-1:0]     idx,
  input  logic [rde_pkg::IN_VALUE_W-1:0]    in_value,
  input  rde_pkg::alpha_cfg_t               cfg,
  output logic                              q_zero,
  output logic                              out_valid,
  output logic [rde_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                              out_last,
  output logic [1:0]                        out_status
);
  import rde_pkg::*;

  localparam int NCH   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int QW    = NCH * STEP_BITS;
  localparam int DEPTH = VALUE_BITS;
  localparam int LB    = (VALUE_BITS < IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

  logic [QW-1:0]      q_r, q_step;
  logic [COUNT_W-1:0] rem_r, rem_step;
  logic [CHAR_W-1:0]  mem [DEPTH];
  logic [CHAR_W-1:0]  char_r;
  logic               out_valid_r;
  logic               out_last_r;
  status_t            out_status_r;

  // one chunk of restoring division: shift a dividend bit in, subtract base if it fits
  always_comb begin
    rem_step = rem_r;
    q_step   = q_r;
    for (int k = 0; k < STEP_BITS; k++) begin
      rem_step = {rem_step[COUNT_W-2:0], q_step[QW-1]};
      q_step   = {q_step[QW-2:0], 1'b0};
      if (rem_step >= cfg.base) begin
        rem_step  = rem_step - cfg.base;
        q_step[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r   <= QW'(in_value[LB-1:0]);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      q_r   <= q_step;
      rem_r <= rem_step;
    end else if (cmd.store) begin
      rem_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[idx] <= cfg.alpha[rem_r[SLOT_W-1:0]];
    end
    if (cmd.rd) begin
      char_r <= mem[idx];
    end else if (cmd.special) begin
      char_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.rd || cmd.special;
    end
    out_last_r   <= cmd.rd ? cmd.last : 1'b1;
    out_status_r <= cmd.rd ? ST_DIGIT : cmd.spec_status;
  end

  assign q_zero         = (q_r == '0);
  assign out_valid      = out_valid_r;
  assign out_digit_char = char_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

  `ASSERT_SYNC(a_special_beat, (out_valid_r && out_status_r != ST_DIGIT) |-> (char_r == '0 && out_last_r), "status beat with a symbol or not last")
  `ASSERT_SYNC(a_rem_below_base, $past(cmd.div_step) |-> (rem_r < cfg.base), "remainder not below base")
  `ASSERT_SYNC(a_load_clears_rem, $past(cmd.load) |-> (rem_r == '0), "remainder not cleared on load")

endmodule

`default_nettype wire

[rtl/radix_digit_emitter_unit.sv]
// Radix digit emitter: top level joining configuration, sequencer and datapath.
// Depends on rde_pkg, rde_cfg, rde_ctrl and rde_dpath.
//
// Usage:
//   Configuration: write symbol_count (index 0), alphabet_low (1) and
//   alphabet_high (2) on cfg_valid/cfg_index/cfg_data; cfg_ready drops while busy
//   or start is high. The alphabet check is registered from the written registers.
//   Input: a beat is taken when start is high and busy is low; busy then stays
//   high until the item's last result has been issued.
//   Output: each result is on out_* for one cycle with out_valid high; the last
//   result of an item has out_last set. The receiver cannot stall the block.
// Sequence:
//   Suppressed zero or bad alphabet: a single status beat, with no symbol.
//   Otherwise each digit is found by dividing by the base in chunks of 8
//   quotient bits and then stored; once the quotient is zero the digits are
//   read back from the digit store one a cycle, most significant first.
// Reset: synchronous, active low; clears the configuration registers to zero (empty
//   alphabet, flagged invalid), clears out_valid and returns the sequencer to idle.
`default_nettype none

module radix_digit_emitter_unit #(
  parameter int VALUE_BITS  = rde_pkg::DEF_VALUE_BITS,
  parameter int MAX_SYMBOLS = rde_pkg::DEF_MAX_SYMBOLS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rde_pkg::IN_VALUE_W-1:0]    in_value,
  input  logic                              in_suppress_zero,
  output logic                              out_valid,
  output logic [rde_pkg::CHAR_W-1:0]        out_digit_char,
  output logic                              out_last,
  output logic [1:0]                        out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rde_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rde_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rde_pkg::*;

  localparam int IW = $clog2(VALUE_BITS);

  alpha_cfg_t    cfg_s;
  logic          alpha_bad;
  logic          q_zero;
  dp_cmd_t       cmd;
  logic [IW-1:0] idx;

  rde_cfg #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg_s),
    .alpha_bad (alpha_bad)
  );

  rde_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_suppress_zero (in_suppress_zero),
    .busy             (busy),
    .q_zero           (q_zero),
    .alpha_bad        (alpha_bad),
    .cmd              (cmd),
    .idx              (idx)
  );

  rde_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .idx            (idx),
    .in_value       (in_value),
    .cfg            (cfg_s),
    .q_zero         (q_zero),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule

`default_nettype wire
